// ===== design/ldfc_pkg.sv =====
// Shared types, constants and helper functions for the length-framed deframer.
package ldfc_pkg;

  // Header layout
  localparam int unsigned HdrBytes   = 20;
  localparam int unsigned HdrCntW    = $clog2(HdrBytes);
  localparam int unsigned MetaLenW   = 32;
  localparam int unsigned PayLenW    = 41;
  localparam int unsigned PayShiftW  = 64;

  localparam logic [HdrCntW-1:0] PosMagicEnd = HdrCntW'(4);
  localparam logic [HdrCntW-1:0] PosVerLo    = HdrCntW'(5);
  localparam logic [HdrCntW-1:0] PosFlagsLo  = HdrCntW'(7);
  localparam logic [HdrCntW-1:0] PosFlagsEnd = HdrCntW'(8);
  localparam logic [HdrCntW-1:0] PosMetaEnd  = HdrCntW'(12);
  localparam logic [HdrCntW-1:0] PosPayFirst = HdrCntW'(12);
  localparam logic [HdrCntW-1:0] PosHdrLast  = HdrCntW'(HdrBytes - 1);

  // Reported payload length saturates at 2^40
  localparam logic [PayLenW-1:0] PayLenSat = PayLenW'(64'h100_0000_0000);

  // Status codes
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StShortHdr  = 3'd1;
  localparam logic [2:0] StMagic     = 3'd2;
  localparam logic [2:0] StVersion   = 3'd3;
  localparam logic [2:0] StFlags     = 3'd4;
  localparam logic [2:0] StTooLarge  = 3'd5;
  localparam logic [2:0] StTruncated = 3'd6;
  localparam logic [2:0] StTrailing  = 3'd7;

  // Section labels
  localparam logic [1:0] SecHeader   = 2'd0;
  localparam logic [1:0] SecMeta     = 2'd1;
  localparam logic [1:0] SecPayload  = 2'd2;
  localparam logic [1:0] SecDropped  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CfgVersion  = 2'd0;
  localparam logic [1:0] CfgMaxMeta  = 2'd1;
  localparam logic [1:0] CfgMaxPay   = 2'd2;

  localparam logic [15:0]         RstVersion = 16'd1;
  localparam logic [MetaLenW-1:0] RstMaxMeta = MetaLenW'(32'h0010_0000);
  localparam logic [PayLenW-1:0]  RstMaxPay  = PayLenW'(32'h2000_0000);

  // CRC-32, reflected
  localparam logic [31:0] CrcPoly = 32'hedb8_8320;
  localparam logic [31:0] CrcInit = 32'hffff_ffff;

  typedef struct packed {
    logic [15:0]         version;
    logic [MetaLenW-1:0] max_meta;
    logic [PayLenW-1:0]  max_pay;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic [1:0]          section;
    logic                frame_done;
    logic [2:0]          status;
    logic [MetaLenW-1:0] metadata_len;
    logic [PayLenW-1:0]  payload_len;
    logic [31:0]         payload_crc;
  } res_t;

  // Expected magic byte for header positions 0 to 3
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h4a;
      2'd1:    m = 8'h46;
      2'd2:    m = 8'h53;
      default: m = 8'h54;
    endcase
    return m;
  endfunction

  // Advance the CRC by one byte, LSB first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== design/ldfc_cfg_regs.sv =====
// Configuration registers: version and length limits.
module ldfc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  output ldfc_pkg::cfg_t      cfg_o
);

  ldfc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ldfc_pkg::CfgVersion: cfg_d.version  = cfg_data_i[15:0];
        ldfc_pkg::CfgMaxMeta: cfg_d.max_meta = cfg_data_i[ldfc_pkg::MetaLenW-1:0];
        ldfc_pkg::CfgMaxPay:  cfg_d.max_pay  = cfg_data_i[ldfc_pkg::PayLenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.version  <= ldfc_pkg::RstVersion;
      cfg_q.max_meta <= ldfc_pkg::RstMaxMeta;
      cfg_q.max_pay  <= ldfc_pkg::RstMaxPay;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== design/ldfc_in_stage.sv =====
// Input register stage for incoming frame bytes.
module ldfc_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  ldfc_pkg::in_t  data_i,
  output logic           valid_o,
  input  logic           take_i,
  output ldfc_pkg::in_t  data_o
);

  logic          valid_q;
  ldfc_pkg::in_t data_q;

  // Refill when empty or whenever the held request moves on this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

// ===== design/ldfc_parser.sv =====
// Frame parser: header checks, section tracking, payload CRC and final status.
module ldfc_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ldfc_pkg::cfg_t cfg_i,
  input  logic           step_i,
  input  ldfc_pkg::in_t  in_i,
  output ldfc_pkg::res_t res_o
);

  localparam int unsigned CntW = ldfc_pkg::HdrCntW;
  localparam int unsigned MW   = ldfc_pkg::MetaLenW;
  localparam int unsigned PW   = ldfc_pkg::PayLenW;
  localparam int unsigned SW   = ldfc_pkg::PayShiftW;

  logic [CntW-1:0] pos_q,      pos_d;
  logic            hdr_done_q, hdr_done_d;
  logic [2:0]      err_q,      err_d;
  logic [SW-1:0]   shift_q,    shift_d;
  logic [MW-1:0]   meta_q,     meta_d;
  logic [MW-1:0]   meta_rem_q, meta_rem_d;
  logic [PW-1:0]   pay_rem_q,  pay_rem_d;
  logic [31:0]     crc_q,      crc_d;

  logic [7:0]      b;
  logic [1:0]      sec;
  logic            short_hdr;
  logic [2:0]      st;

  assign b = in_i.data_byte;

  always_comb begin
    pos_d      = pos_q;
    hdr_done_d = hdr_done_q;
    err_d      = err_q;
    shift_d    = shift_q;
    meta_d     = meta_q;
    meta_rem_d = meta_rem_q;
    pay_rem_d  = pay_rem_q;
    crc_d      = crc_q;
    sec        = ldfc_pkg::SecHeader;

    if (!hdr_done_q) begin
      pos_d = pos_q + CntW'(1);
      if (pos_q < ldfc_pkg::PosMagicEnd) begin
        if (err_q == ldfc_pkg::StOk && b != ldfc_pkg::magic_byte(pos_q[1:0])) begin
          err_d = ldfc_pkg::StMagic;
        end
      end else if (pos_q < ldfc_pkg::PosFlagsEnd) begin
        // Version and flags pass through the low 16 bits of the shifter
        shift_d = {{(SW-16){1'b0}}, shift_q[7:0], b};
        if (err_q == ldfc_pkg::StOk && pos_q == ldfc_pkg::PosVerLo &&
            shift_d[15:0] != cfg_i.version) begin
          err_d = ldfc_pkg::StVersion;
        end
        if (err_q == ldfc_pkg::StOk && pos_q == ldfc_pkg::PosFlagsLo &&
            shift_d[15:0] != 16'd0) begin
          err_d = ldfc_pkg::StFlags;
        end
      end else if (pos_q < ldfc_pkg::PosMetaEnd) begin
        meta_d = {meta_q[MW-9:0], b};
      end else if (pos_q == ldfc_pkg::PosPayFirst) begin
        shift_d = {{(SW-8){1'b0}}, b};
      end else begin
        shift_d = {shift_q[SW-9:0], b};
      end

      if (pos_q == ldfc_pkg::PosHdrLast) begin
        hdr_done_d = 1'b1;
        meta_rem_d = meta_d;
        pay_rem_d  = shift_d[PW-1:0];
        if (err_q == ldfc_pkg::StOk &&
            (meta_d == '0 || meta_d > cfg_i.max_meta ||
             shift_d > {{(SW-PW){1'b0}}, cfg_i.max_pay})) begin
          err_d = ldfc_pkg::StTooLarge;
        end
      end
    end else begin
      // Body: drop bytes after an error; else count down metadata, then payload, then flag trailing bytes
      if (err_q != ldfc_pkg::StOk) begin
        sec = ldfc_pkg::SecDropped;
      end else if (meta_rem_q != '0) begin
        sec        = ldfc_pkg::SecMeta;
        meta_rem_d = meta_rem_q - MW'(1);
      end else if (pay_rem_q != '0) begin
        sec       = ldfc_pkg::SecPayload;
        pay_rem_d = pay_rem_q - PW'(1);
        crc_d     = ldfc_pkg::crc32_byte(crc_q, b);
      end else begin
        sec   = ldfc_pkg::SecDropped;
        err_d = ldfc_pkg::StTrailing;
      end
    end
  end

  assign short_hdr = !hdr_done_d;

  always_comb begin
    if (short_hdr) begin
      st = ldfc_pkg::StShortHdr;
    end else if (err_d != ldfc_pkg::StOk) begin
      st = err_d;
    end else if (meta_rem_d != '0 || pay_rem_d != '0) begin
      st = ldfc_pkg::StTruncated;
    end else begin
      st = ldfc_pkg::StOk;
    end
  end

  always_comb begin
    res_o              = '0;
    res_o.out_byte     = b;
    res_o.section      = sec;
    res_o.frame_done   = in_i.frame_end;
    if (in_i.frame_end) begin
      res_o.status      = st;
      res_o.payload_crc = ~crc_d;
      if (!short_hdr) begin
        res_o.metadata_len = meta_d;
        res_o.payload_len  = (shift_d > {{(SW-PW){1'b0}}, ldfc_pkg::PayLenSat}) ?
                             ldfc_pkg::PayLenSat : shift_d[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hdr_done_q <= 1'b0;
      err_q      <= ldfc_pkg::StOk;
      shift_q    <= '0;
      meta_q     <= '0;
      meta_rem_q <= '0;
      pay_rem_q  <= '0;
      crc_q      <= ldfc_pkg::CrcInit;
    end else if (step_i) begin
      if (in_i.frame_end) begin
        // Clear frame state after the last byte
        pos_q      <= '0;
        hdr_done_q <= 1'b0;
        err_q      <= ldfc_pkg::StOk;
        shift_q    <= '0;
        meta_q     <= '0;
        meta_rem_q <= '0;
        pay_rem_q  <= '0;
        crc_q      <= ldfc_pkg::CrcInit;
      end else begin
        pos_q      <= pos_d;
        hdr_done_q <= hdr_done_d;
        err_q      <= err_d;
        shift_q    <= shift_d;
        meta_q     <= meta_d;
        meta_rem_q <= meta_rem_d;
        pay_rem_q  <= pay_rem_d;
        crc_q      <= crc_d;
      end
    end
  end

endmodule

// ===== design/ldfc_out_stage.sv =====
// Result register stage in front of the output stream.
module ldfc_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  ldfc_pkg::res_t  res_i,
  output logic            valid_o,
  input  logic            ready_i,
  output ldfc_pkg::res_t  res_o
);

  logic           valid_q;
  ldfc_pkg::res_t res_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== design/length_framed_deframer_crc32_core.sv =====
// Length-framed deframer with header checks and payload CRC-32, top level.
// Each input request passes through the input register, then the result register.
// Throughput: one byte per cycle; the combinational parse step between the two
// registers handles a byte in every cycle while the output is not stalled.
// Reset (rst_ni low, asynchronous): both stages empty, frame state cleared,
// version register 1, metadata limit 2^20, payload limit 2^29.
module length_framed_deframer_crc32_core (
  input  logic          clk_i,
  input  logic          rst_ni,

  // Input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic          s_axis_tlast,   // frame_end

  // Result stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [7:0] out_byte, [10:8] status, [42:11] metadata_len,
  // [83:43] payload_len, [115:84] payload_crc, [119:116] zero
  output logic [119:0]  m_axis_tdata,
  output logic [1:0]    m_axis_tuser,   // [1:0] section
  output logic          m_axis_tlast,   // frame_done

  // Configuration writes
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i
);

  ldfc_pkg::cfg_t cfg;
  ldfc_pkg::in_t  in_req;
  ldfc_pkg::in_t  in_held;
  ldfc_pkg::res_t res_next;
  ldfc_pkg::res_t res_out;
  logic           held_valid;
  logic           out_ready;
  logic           step;

  // Pack the incoming request
  assign in_req.data_byte = s_axis_tdata;
  assign in_req.frame_end = s_axis_tlast;

  // Advance a held byte whenever the result register can take it
  assign step = held_valid && out_ready;

  ldfc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ldfc_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (in_req),
    .valid_o (held_valid),
    .take_i  (out_ready),
    .data_o  (in_held)
  );

  // Parse step: state updates only when the byte moves into the result register
  ldfc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .in_i   (in_held),
    .res_o  (res_next)
  );

  ldfc_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (held_valid),
    .ready_o (out_ready),
    .res_i   (res_next),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  // Unpack the result onto the stream fields
  assign m_axis_tdata = {4'd0,
                         res_out.payload_crc,
                         res_out.payload_len,
                         res_out.metadata_len,
                         res_out.status,
                         res_out.out_byte};
  assign m_axis_tuser = res_out.section;
  assign m_axis_tlast = res_out.frame_done;

endmodule

// ===== tb/length_framed_deframer_crc32_core_tb.sv =====
// Self-checking testbench for the length-framed deframer with payload CRC-32.
module length_framed_deframer_crc32_core_tb;
  import ldfc_pkg::*;

  localparam logic [31:0] FrameMagic   = {8'h4a, 8'h46, 8'h53, 8'h54};
  localparam int          CycleLimit   = 200000;
  localparam int          RxHoldCycles = 300;
  localparam int          DrainCycles  = 10;
  localparam int          NumPhases    = 6;
  localparam int          PhaseBytes   = 76;
  localparam int          MaxPrints    = 30;
  localparam int          DirRows      = 25;

  typedef enum int {
    FrGood, FrBadMagic, FrBadVersion, FrBadFlags, FrTooLarge,
    FrTruncated, FrTrailing, FrShort, FrNoise
  } frame_kind_e;

  // Directed row: request plus, where fixed is set, the result typed in by hand
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        fixed;
    logic [1:0]  section;
    logic [2:0]  status;
    logic [31:0] meta_len;
    logic [40:0] pay_len;
    logic [31:0] crc;
  } dir_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [7:0]    s_axis_tdata;   // [7:0] data_byte
  logic          s_axis_tlast;   // frame_end
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  // [7:0] out_byte, [10:8] status, [42:11] metadata_len,
  // [83:43] payload_len, [115:84] payload_crc, [119:116] zero
  logic [119:0]  m_axis_tdata;
  logic [1:0]    m_axis_tuser;   // [1:0] section
  logic          m_axis_tlast;   // frame_done
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i;
  logic [63:0]   cfg_data_i;

  length_framed_deframer_crc32_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor copy of the configuration
  logic [15:0] ver_cfg;
  logic [31:0] max_meta_cfg;
  logic [40:0] max_pay_cfg;

  // Predictor copy of the frame state
  logic [47:0] pos_q;
  logic [31:0] meta_len_q;
  logic [63:0] pay_len_q;
  logic [2:0]  fault_q;
  logic [31:0] crc_q;

  res_t        pending_results[$];
  logic [7:0]  frame_bytes[$];
  int          mismatch_cnt;
  int          cycle_cnt;
  bit          idle_en = 1'b1;
  bit          rx_hold_req = 1'b0;

  // Short frames, one full frame with one metadata and two payload bytes
  dir_row_t dir_table [DirRows] = '{
    '{8'hff, 1'b1, 1'b1, SecHeader, StShortHdr, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b1, 1'b1, SecHeader, StShortHdr, 32'd0, 41'd0, 32'd0},
    '{8'h4a, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h46, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h53, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h54, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h01, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h01, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h02, 1'b0, 1'b1, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h5a, 1'b0, 1'b1, SecMeta, StOk, 32'd0, 41'd0, 32'd0},
    '{8'hff, 1'b0, 1'b0, SecHeader, StOk, 32'd0, 41'd0, 32'd0},
    '{8'h00, 1'b1, 1'b0, SecHeader, StOk, 32'd0, 41'd0, 32'd0}
  };

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrints)
      $display("mismatch %0s: got %0h want %0h (cycle %0d)", what, got, want, cycle_cnt);
  endtask

  function automatic void clear_frame_state();
    pos_q      = '0;
    meta_len_q = '0;
    pay_len_q  = '0;
    fault_q    = StOk;
    crc_q      = CrcInit;
  endfunction

  // Append one byte to the frame under construction
  function automatic void append_byte(input logic [7:0] v);
    frame_bytes = {frame_bytes, v};
  endfunction

  // Reflected CRC-32, one data bit per step, LSB first
  function automatic logic [31:0] crc32_advance(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) c = (c >> 1) ^ CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

  // Advance the frame state by one byte and return its result
  function automatic res_t deframe_byte(input logic [7:0] b, input logic last);
    res_t        r;
    logic [47:0] pos;
    logic [63:0] off;
    logic [63:0] need;
    r = '0;
    r.out_byte = b;
    r.frame_done = last;
    pos = pos_q;
    if (pos < HdrBytes) begin
      r.section = SecHeader;
      if (pos < 4) begin
        if (fault_q == StOk && b != FrameMagic[8*(3 - pos[1:0]) +: 8]) fault_q = StMagic;
      end else if (pos < 8) begin
        // version and flags share the low 16 bits of the payload shifter
        pay_len_q = {48'd0, pay_len_q[7:0], b};
        if (fault_q == StOk && pos == 5 && pay_len_q[15:0] != ver_cfg) fault_q = StVersion;
        if (fault_q == StOk && pos == 7 && pay_len_q != 64'd0) fault_q = StFlags;
      end else if (pos < 12) begin
        meta_len_q = {meta_len_q[23:0], b};
      end else if (pos == 12) begin
        pay_len_q = {56'd0, b};
      end else begin
        pay_len_q = {pay_len_q[55:0], b};
      end
      if (pos == HdrBytes - 1 && fault_q == StOk &&
          (meta_len_q == 32'd0 || meta_len_q > max_meta_cfg ||
           pay_len_q > 64'(max_pay_cfg)))
        fault_q = StTooLarge;
    end else begin
      off = 64'(pos) - HdrBytes;
      if (fault_q != StOk) begin
        r.section = SecDropped;
      end else if (off < 64'(meta_len_q)) begin
        r.section = SecMeta;
      end else if (off - 64'(meta_len_q) < pay_len_q) begin
        r.section = SecPayload;
        crc_q = crc32_advance(crc_q, b);
      end else begin
        fault_q = StTrailing;
        r.section = SecDropped;
      end
    end
    if (pos != '1) pos_q = pos + 48'd1;
    if (last) begin
      need = 64'(meta_len_q) + pay_len_q;
      if (pos_q < HdrBytes) r.status = StShortHdr;
      else if (fault_q != StOk) r.status = fault_q;
      else if (64'(pos_q) - HdrBytes < need) r.status = StTruncated;
      else r.status = StOk;
      if (pos_q >= HdrBytes) begin
        r.metadata_len = meta_len_q;
        r.payload_len = (pay_len_q > 64'(PayLenSat)) ? PayLenSat : pay_len_q[40:0];
      end
      r.payload_crc = ~crc_q;
      clear_frame_state();
    end
    return r;
  endfunction

  // Offer one byte, with an optional idle burst first; valid stays high afterwards
  task automatic send_byte(input logic [7:0] b, input logic last, input logic use_fixed,
                           input res_t fixed_res);
    res_t pred;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = deframe_byte(b, last);
    pending_results = {pending_results, (use_fixed ? fixed_res : pred)};
  endtask

  // Write one register; the caller drops valid after the last write
  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgVersion: ver_cfg = val[15:0];
      CfgMaxMeta: max_meta_cfg = val[31:0];
      CfgMaxPay:  max_pay_cfg = val[40:0];
      default: ;
    endcase
  endtask

  // Build the next frame under the current limits, well formed for 9 of the 20 picks
  task automatic make_frame();
    int          pick;
    int          body;
    frame_kind_e kind;
    logic [31:0] magic;
    logic [15:0] ver;
    logic [15:0] flags;
    logic [31:0] mlen;
    logic [63:0] plen;
    logic [63:0] total;
    frame_bytes.delete();
    pick = $urandom_range(0, 19);
    if (pick < 9) kind = FrGood;
    else if (pick == 9) kind = FrBadMagic;
    else if (pick == 10) kind = FrBadVersion;
    else if (pick == 11) kind = FrBadFlags;
    else if (pick == 12) kind = FrTooLarge;
    else if (pick < 15) kind = FrTruncated;
    else if (pick < 17) kind = FrTrailing;
    else if (pick == 17) kind = FrShort;
    else kind = FrNoise;

    if (kind == FrNoise) begin
      repeat ($urandom_range(1, 30)) append_byte(8'($urandom_range(0, 255)));
      return;
    end

    magic = FrameMagic;
    ver   = ver_cfg;
    flags = 16'd0;
    mlen  = $urandom_range(1, (max_meta_cfg < 32'd6) ? max_meta_cfg : 32'd6);
    plen  = $urandom_range(0, (max_pay_cfg < 41'd12) ? 32'(max_pay_cfg) : 32'd12);
    case (kind)
      FrBadMagic:   magic = magic ^ (32'd1 << $urandom_range(0, 31));
      FrBadVersion: ver = ver ^ 16'($urandom_range(1, 65535));
      FrBadFlags:   flags = 16'($urandom_range(1, 65535));
      FrTooLarge: begin
        case ($urandom_range(0, 3))
          0: mlen = 32'd0;
          1: begin
            if (max_meta_cfg != '1) mlen = max_meta_cfg + 32'd1;
            else plen = {$urandom, $urandom};
          end
          2: plen = 64'(max_pay_cfg) + 64'd1;
          default: plen = {$urandom, $urandom};
        endcase
      end
      FrTruncated: begin
        // big declared lengths, up to the configured limits of both length fields
        if ($urandom_range(0, 1) == 1) begin
          mlen = 32'(64'($urandom) % 64'(max_meta_cfg)) + 32'd1;
          plen = {$urandom, $urandom} % (64'(max_pay_cfg) + 64'd1);
        end
      end
      default: ;
    endcase

    for (int i = 3; i >= 0; i--) append_byte(magic[8*i +: 8]);
    append_byte(ver[15:8]);
    append_byte(ver[7:0]);
    append_byte(flags[15:8]);
    append_byte(flags[7:0]);
    for (int i = 3; i >= 0; i--) append_byte(mlen[8*i +: 8]);
    for (int i = 7; i >= 0; i--) append_byte(plen[8*i +: 8]);

    total = 64'(mlen) + plen;
    case (kind)
      FrBadMagic, FrBadVersion, FrBadFlags, FrTooLarge: body = $urandom_range(0, 8);
      FrTruncated: begin
        if (total > 64'd10) body = $urandom_range(0, 10);
        else body = $urandom_range(0, 32'(total) - 1);
      end
      FrTrailing: body = int'(total) + $urandom_range(1, 4);
      FrShort:    body = 0;
      default:    body = int'(total);
    endcase
    repeat (body) append_byte(8'($urandom_range(0, 255)));
    if (kind == FrShort) begin
      body = $urandom_range(1, HdrBytes - 1);
      while (frame_bytes.size() > body) void'(frame_bytes.pop_back());
    end
  endtask

  // Result sink: random stalls, plus one long hold-off to back the block up
  initial begin : result_sink
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t got;
    res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.out_byte     = m_axis_tdata[7:0];
      got.status       = m_axis_tdata[10:8];
      got.metadata_len = m_axis_tdata[42:11];
      got.payload_len  = m_axis_tdata[83:43];
      got.payload_crc  = m_axis_tdata[115:84];
      got.section      = m_axis_tuser;
      got.frame_done   = m_axis_tlast;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", got.out_byte, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.out_byte !== want.out_byte)
          report_mismatch("out_byte", got.out_byte, want.out_byte);
        if (got.section !== want.section)
          report_mismatch("section", got.section, want.section);
        if (got.frame_done !== want.frame_done)
          report_mismatch("frame_done", got.frame_done, want.frame_done);
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.metadata_len !== want.metadata_len)
          report_mismatch("metadata_len", got.metadata_len, want.metadata_len);
        if (got.payload_len !== want.payload_len)
          report_mismatch("payload_len", got.payload_len, want.payload_len);
        if (got.payload_crc !== want.payload_crc)
          report_mismatch("payload_crc", got.payload_crc, want.payload_crc);
      end
    end
  end

  initial begin : stimulus
    int          row;
    int          phase;
    int          phase_bytes;
    res_t        want;
    logic [15:0] ver_w;
    logic [31:0] meta_w;
    logic [40:0] pay_w;

    mismatch_cnt = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CfgVersion;
    cfg_data_i    <= 64'd0;
    ver_cfg      = RstVersion;
    max_meta_cfg = RstMaxMeta;
    max_pay_cfg  = RstMaxPay;
    clear_frame_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run under the reset register values
    for (row = 0; row < DirRows; row++) begin
      want = '0;
      want.out_byte   = dir_table[row].data;
      want.frame_done = dir_table[row].last;
      want.section    = dir_table[row].section;
      if (dir_table[row].last) begin
        want.status       = dir_table[row].status;
        want.metadata_len = dir_table[row].meta_len;
        want.payload_len  = dir_table[row].pay_len;
        want.payload_crc  = dir_table[row].crc;
      end
      send_byte(dir_table[row].data, dir_table[row].last, dir_table[row].fixed, want);
    end

    for (phase = 0; phase < NumPhases; phase++) begin
      // Let the block drain before touching the registers
      s_axis_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      repeat (DrainCycles) @(posedge clk_i);

      case (phase)
        0: begin
          ver_w  = 16'($urandom);
          meta_w = 32'hffff_ffff;
          pay_w  = PayLenSat;
        end
        1: begin
          ver_w  = 16'd0;
          meta_w = 32'd1;
          pay_w  = 41'd0;
        end
        2: begin
          ver_w  = 16'hffff;
          meta_w = $urandom_range(1, 8);
          pay_w  = $urandom_range(0, 16);
        end
        default: begin
          ver_w  = 16'($urandom);
          meta_w = $urandom_range(1, 8);
          if ($urandom_range(0, 1) == 1) pay_w = $urandom_range(0, 16);
          else pay_w = {1'b0, 8'($urandom), $urandom};
        end
      endcase
      cfg_write(CfgVersion, 64'(ver_w));
      cfg_write(CfgMaxMeta, 64'(meta_w));
      cfg_write(CfgMaxPay, 64'(pay_w));
      cfg_valid_i <= 1'b0;

      if (phase == 1) rx_hold_req = 1'b1;
      idle_en = (phase != NumPhases - 1);

      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        make_frame();
        foreach (frame_bytes[i])
          send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
        phase_bytes += frame_bytes.size();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
